// ===== design/rotation_matrix_to_quaternion_top_macros.svh =====
// Assertion macros used by the quaternion converter port checker.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

// check a property at every clock edge outside reset
`define RMQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition is followed by a consequence in the next clock cycle
`define RMQ_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) else $error(msg);

`endif

// ===== design/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

   localparam int IN_W       = 18;
   localparam int OUT_W      = 18;
   localparam int ELEM_N     = 9;
   localparam int COMP_N     = 4;
   localparam int NORM_W     = 62;
   localparam int ROOT_W     = 31;
   localparam int INV_W      = 33;
   localparam int PROD_W     = 64;
   localparam int K_W        = 5;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 72;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
   localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

// ===== design/rmq_front.sv =====
// Component selection, sum of squares and normalizing shift stages.
module rmq_front import rmq_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pipe_ctl_type                          in_ctl,
   input  logic [ELEM_N-1:0][IN_W-1:0]           in_m,
   output logic                                  out_valid,
   output logic [NORM_W-1:0]                     out_rad,
   output logic [COMP_N-1:0]                     out_neg,
   output logic                                  out_zero,
   output logic [COMP_N-1:0][ROOT_W-1:0]         out_amag
);

   localparam int MAG_W = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 2;
   localparam int CW    = MAG_W + 1;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int S_W   = SQ_W + 2;
   localparam logic signed [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

   typedef enum logic [1:0] {PICK_X, PICK_Y, PICK_Z} pick_type;

   logic [5:0]                vld_ff;

   logic signed [CW-1:0]      mx [ELEM_N];
   logic signed [CW-1:0]      trace;
   logic signed [CW-1:0]      best;
   pick_type                  pick_in;
   logic signed [CW-1:0]      m_ff [ELEM_N];
   logic                      tpos_ff;
   pick_type                  pick_ff;

   logic signed [CW-1:0]      q_in [COMP_N];
   logic signed [CW-1:0]      q_ff [COMP_N];

   logic [MAG_W-1:0]          mag_in [COMP_N];
   logic [COMP_N-1:0]         neg3_ff;
   logic [MAG_W-1:0]          mag3_ff [COMP_N];
   logic [SQ_W-1:0]           sq_ff [COMP_N];

   logic [COMP_N-1:0]         neg4_ff;
   logic [MAG_W-1:0]          mag4_ff [COMP_N];
   logic [S_W-1:0]            sum_ff;

   logic [NORM_W-1:0]         s62;
   logic [K_W-1:0]            k_in;
   logic [COMP_N-1:0]         neg5_ff;
   logic [MAG_W-1:0]          mag5_ff [COMP_N];
   logic [NORM_W-1:0]         rad5_ff;
   logic [K_W-1:0]            k_ff;
   logic                      zero5_ff;

   logic [NORM_W-1:0]         rad_ff;
   logic [COMP_N-1:0]         neg_ff;
   logic                      zero_ff;
   logic [COMP_N-1:0][ROOT_W-1:0] amag_ff;

   always_comb begin
      for (int i = 0; i < ELEM_N; i++) begin
         mx[i] = CW'($signed(in_m[i]));
      end
      trace   = mx[0] + mx[4] + mx[8];
      best    = mx[0];
      pick_in = PICK_X;
      if (mx[4] > best) begin
         best    = mx[4];
         pick_in = PICK_Y;
      end
      if (mx[8] > best) begin
         pick_in = PICK_Z;
      end
   end

   always_comb begin
      if (tpos_ff) begin
         q_in[0] = m_ff[7] - m_ff[5];
         q_in[1] = m_ff[2] - m_ff[6];
         q_in[2] = m_ff[3] - m_ff[1];
         q_in[3] = ONE + m_ff[0] + m_ff[4] + m_ff[8];
      end else begin
         case (pick_ff)
            PICK_X: begin
               q_in[0] = ONE + m_ff[0] - m_ff[4] - m_ff[8];
               q_in[1] = m_ff[3] + m_ff[1];
               q_in[2] = m_ff[6] + m_ff[2];
               q_in[3] = m_ff[7] - m_ff[5];
            end
            PICK_Y: begin
               q_in[0] = m_ff[1] + m_ff[3];
               q_in[1] = ONE - m_ff[0] + m_ff[4] - m_ff[8];
               q_in[2] = m_ff[7] + m_ff[5];
               q_in[3] = m_ff[2] - m_ff[6];
            end
            default: begin
               q_in[0] = m_ff[2] + m_ff[6];
               q_in[1] = m_ff[5] + m_ff[7];
               q_in[2] = ONE - m_ff[0] - m_ff[4] + m_ff[8];
               q_in[3] = m_ff[3] - m_ff[1];
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         mag_in[i] = q_ff[i][CW-1] ? MAG_W'(-q_ff[i]) : MAG_W'(q_ff[i]);
      end
   end

   always_comb begin
      s62  = NORM_W'(sum_ff);
      k_in = '0;
      for (int j = 0; j < ROOT_W; j++) begin
         if (s62[2*j+1 -: 2] != 2'b00) begin
            k_in = K_W'(ROOT_W - 1 - j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (in_ctl.advance) begin
         vld_ff <= {vld_ff[4:0], in_ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         m_ff    <= mx;
         tpos_ff <= (trace > 0);
         pick_ff <= pick_in;

         q_ff <= q_in;

         for (int i = 0; i < COMP_N; i++) begin
            neg3_ff[i] <= q_ff[i][CW-1];
            mag3_ff[i] <= mag_in[i];
            sq_ff[i]   <= mag_in[i] * mag_in[i];
         end

         neg4_ff <= neg3_ff;
         mag4_ff <= mag3_ff;
         sum_ff  <= S_W'(sq_ff[0]) + S_W'(sq_ff[1]) + S_W'(sq_ff[2]) + S_W'(sq_ff[3]);

         neg5_ff  <= neg4_ff;
         mag5_ff  <= mag4_ff;
         rad5_ff  <= s62;
         k_ff     <= k_in;
         zero5_ff <= (sum_ff == '0);

         rad_ff  <= rad5_ff << {k_ff, 1'b0};
         neg_ff  <= neg5_ff;
         zero_ff <= zero5_ff;
         for (int i = 0; i < COMP_N; i++) begin
            amag_ff[i] <= ROOT_W'(mag5_ff[i]) << k_ff;
         end
      end
   end

   assign out_valid = vld_ff[5];
   assign out_rad   = rad_ff;
   assign out_neg   = neg_ff;
   assign out_zero  = zero_ff;
   assign out_amag  = amag_ff;

endmodule

// ===== design/rmq_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rmq_sqrt import rmq_pkg::*; #(
   parameter int TAG_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  pipe_ctl_type       in_ctl,
   input  logic [NORM_W-1:0]  in_rad,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output logic [TAG_W-1:0]   out_tag
);

   localparam int REM_W = ROOT_W + 3;

   logic [ROOT_W-1:0] vld_ff;
   logic [NORM_W-1:0] rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (in_ctl.advance) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_ctl.valid};
      end
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic [NORM_W-1:0] src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      logic [TAG_W-1:0]  src_tag;
      logic [REM_W-1:0]  partial;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (i == 0) begin : g_first
         assign src_rad  = in_rad;
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_tag  = in_tag;
      end else begin : g_next
         assign src_rad  = rad_ff[i-1];
         assign src_rem  = rem_ff[i-1];
         assign src_root = root_ff[i-1];
         assign src_tag  = tag_ff[i-1];
      end

      assign partial = {src_rem[REM_W-3:0], src_rad[NORM_W-1 -: 2]};
      assign trial   = REM_W'({src_root, 2'b01});
      assign ge      = (partial >= trial);

      always_ff @(posedge clock) begin
         if (in_ctl.advance) begin
            rad_ff[i]  <= src_rad << 2;
            rem_ff[i]  <= ge ? (partial - trial) : partial;
            root_ff[i] <= {src_root[ROOT_W-2:0], ge};
            tag_ff[i]  <= src_tag;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

// ===== design/rmq_recip.sv =====
// Pipelined long division of 2^62 by the root, one quotient bit per stage.
module rmq_recip import rmq_pkg::*; #(
   parameter int TAG_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  pipe_ctl_type       in_ctl,
   input  logic [ROOT_W-1:0]  in_root,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output logic [INV_W-1:0]   out_inv,
   output logic [TAG_W-1:0]   out_tag
);

   localparam logic [ROOT_W-1:0] REM_INIT = {{(ROOT_W-1){1'b0}}, 1'b1} << (NORM_W - INV_W);

   logic [INV_W-1:0]  vld_ff;
   logic [ROOT_W-1:0] div_ff [INV_W];
   logic [ROOT_W-1:0] rem_ff [INV_W];
   logic [INV_W-1:0]  quo_ff [INV_W];
   logic [TAG_W-1:0]  tag_ff [INV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (in_ctl.advance) begin
         vld_ff <= {vld_ff[INV_W-2:0], in_ctl.valid};
      end
   end

   for (genvar i = 0; i < INV_W; i++) begin : g_stage
      logic [ROOT_W-1:0] src_div;
      logic [ROOT_W-1:0] src_rem;
      logic [INV_W-1:0]  src_quo;
      logic [TAG_W-1:0]  src_tag;
      logic [ROOT_W:0]   partial;
      logic [ROOT_W:0]   diff;
      logic              ge;

      if (i == 0) begin : g_first
         assign src_div = in_root;
         assign src_rem = REM_INIT;
         assign src_quo = '0;
         assign src_tag = in_tag;
      end else begin : g_next
         assign src_div = div_ff[i-1];
         assign src_rem = rem_ff[i-1];
         assign src_quo = quo_ff[i-1];
         assign src_tag = tag_ff[i-1];
      end

      assign partial = {src_rem, 1'b0};
      assign ge      = (partial >= {1'b0, src_div});
      assign diff    = partial - {1'b0, src_div};

      always_ff @(posedge clock) begin
         if (in_ctl.advance) begin
            div_ff[i] <= src_div;
            rem_ff[i] <= ge ? diff[ROOT_W-1:0] : partial[ROOT_W-1:0];
            quo_ff[i] <= {src_quo[INV_W-2:0], ge};
            tag_ff[i] <= src_tag;
         end
      end
   end

   assign out_valid = vld_ff[INV_W-1];
   assign out_inv   = quo_ff[INV_W-1];
   assign out_tag   = tag_ff[INV_W-1];

endmodule

// ===== design/rmq_scale.sv =====
// Component scaling, rounding, saturation and the result register.
module rmq_scale import rmq_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pipe_ctl_type                   in_ctl,
   input  logic [INV_W-1:0]               in_inv,
   input  logic [COMP_N-1:0]              in_neg,
   input  logic                           in_zero,
   input  logic [COMP_N-1:0][ROOT_W-1:0]  in_amag,
   output logic                           out_valid,
   output logic [COMP_N-1:0][OUT_W-1:0]   out_q,
   output logic                           out_degen
);

   localparam int RND_W = PROD_W + 1;
   localparam logic [RND_W-1:0] HALF    = {{(RND_W-1){1'b0}}, 1'b1} << (61 - FRAC_BITS);
   localparam logic [RND_W-1:0] POS_LIM = RND_W'(OUT_MAX);
   localparam logic [RND_W-1:0] NEG_LIM = {{(RND_W-1){1'b0}}, 1'b1} << (OUT_W - 1);

   logic [1:0]                      vld_ff;
   logic [PROD_W-1:0]               prod_ff [COMP_N];
   logic [COMP_N-1:0]               neg_ff;
   logic                            zero_ff;
   logic [COMP_N-1:0][OUT_W-1:0]    q_in;
   logic [COMP_N-1:0][OUT_W-1:0]    q_ff;
   logic                            degen_ff;
   logic [RND_W-1:0]                rnd;
   logic [RND_W-1:0]                sh;

   always_comb begin
      rnd = '0;
      sh  = '0;
      for (int i = 0; i < COMP_N; i++) begin
         rnd = {1'b0, prod_ff[i]} + HALF;
         sh  = rnd >> (62 - FRAC_BITS);
         if (zero_ff) begin
            q_in[i] = '0;
         end else if (neg_ff[i]) begin
            q_in[i] = (sh > NEG_LIM) ? OUT_MIN : OUT_W'('0 - sh[OUT_W-1:0]);
         end else begin
            q_in[i] = (sh > POS_LIM) ? OUT_MAX : sh[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (in_ctl.advance) begin
         vld_ff <= {vld_ff[0], in_ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         for (int i = 0; i < COMP_N; i++) begin
            prod_ff[i] <= PROD_W'(in_amag[i]) * PROD_W'(in_inv);
         end
         neg_ff   <= in_neg;
         zero_ff  <= in_zero;
         q_ff     <= q_in;
         degen_ff <= zero_ff;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_q     = q_ff;
   assign out_degen = degen_ff;

endmodule

// ===== design/rotation_matrix_to_quaternion_top.sv =====
// Top level of the rotation matrix to unit quaternion converter.
//
// The req channel carries one 3x3 rotation matrix per transfer, nine signed
// Q1.16 entries packed row by row into req_tdata. The rsp channel returns the
// unit quaternion (qx, qy, qz, qw) in rsp_tdata and a degenerate flag in
// rsp_tuser; a degenerate result has all four components at zero.
// The datapath is a single pipeline of 72 register stages: six for component
// selection, sum of squares and normalizing shift, 31 for the bit-per-stage
// square root, 33 for the bit-per-stage reciprocal divider and two for the
// multiplies, rounding and the result register. One matrix is taken in every
// cycle while the pipeline is not stalled by rsp_tready.
// Reset clears every valid bit; the pipeline is empty and rsp_tvalid is low.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; no item is lost or repeated.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // qx, qy, qz, qw
   output logic [0:0]             rsp_tuser    // degenerate
);

   localparam int TAG_W = COMP_N * ROOT_W + COMP_N + 1;

   logic                          advance;
   pipe_ctl_type                  front_ctl;
   pipe_ctl_type                  sqrt_ctl;
   pipe_ctl_type                  recip_ctl;
   pipe_ctl_type                  scale_ctl;

   logic                          front_valid;
   logic [NORM_W-1:0]             front_rad;
   logic [COMP_N-1:0]             front_neg;
   logic                          front_zero;
   logic [COMP_N-1:0][ROOT_W-1:0] front_amag;
   logic [TAG_W-1:0]              front_tag;

   logic                          sqrt_valid;
   logic [ROOT_W-1:0]             sqrt_root;
   logic [TAG_W-1:0]              sqrt_tag;

   logic                          recip_valid;
   logic [INV_W-1:0]              recip_inv;
   logic [TAG_W-1:0]              recip_tag;

   logic [COMP_N-1:0][OUT_W-1:0]  scale_q;
   logic                          scale_degen;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   assign front_ctl = '{advance: advance, valid: req_tvalid};
   assign sqrt_ctl  = '{advance: advance, valid: front_valid};
   assign recip_ctl = '{advance: advance, valid: sqrt_valid};
   assign scale_ctl = '{advance: advance, valid: recip_valid};

   rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (front_ctl),
      .in_m      (req_tdata[ELEM_N*IN_W-1:0]),
      .out_valid (front_valid),
      .out_rad   (front_rad),
      .out_neg   (front_neg),
      .out_zero  (front_zero),
      .out_amag  (front_amag)
   );

   assign front_tag = {front_zero, front_neg, front_amag};

   rmq_sqrt #(.TAG_W(TAG_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (sqrt_ctl),
      .in_rad    (front_rad),
      .in_tag    (front_tag),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_tag   (sqrt_tag)
   );

   rmq_recip #(.TAG_W(TAG_W)) u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (recip_ctl),
      .in_root   (sqrt_root),
      .in_tag    (sqrt_tag),
      .out_valid (recip_valid),
      .out_inv   (recip_inv),
      .out_tag   (recip_tag)
   );

   rmq_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (scale_ctl),
      .in_inv    (recip_inv),
      .in_neg    (recip_tag[COMP_N*ROOT_W +: COMP_N]),
      .in_zero   (recip_tag[TAG_W-1]),
      .in_amag   (recip_tag[COMP_N*ROOT_W-1:0]),
      .out_valid (rsp_tvalid),
      .out_q     (scale_q),
      .out_degen (scale_degen)
   );

   assign rsp_tdata = scale_q;
   assign rsp_tuser = scale_degen;

endmodule

// ===== design/rmq_checker.sv =====
// Port-level assertion checker for the quaternion converter, bound to the top.
`include "rotation_matrix_to_quaternion_top_macros.svh"

module rmq_checker import rmq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata,
   input logic [0:0]             rsp_tuser
);

   `RMQ_ASSERT_NEXT(a_rsp_valid_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp dropped while stalled")
   `RMQ_ASSERT_NEXT(a_rsp_data_hold, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "rsp payload changed while stalled")
   `RMQ_ASSERT_ALWAYS(a_degen_zero, !(rsp_tvalid && rsp_tuser[0]) || (rsp_tdata == '0), "degenerate result with nonzero components")
   `RMQ_ASSERT_ALWAYS(a_ready_rule, req_tready == (!rsp_tvalid || rsp_tready), "req_tready does not follow the output stall")

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);

// ===== verif/rotation_matrix_to_quaternion_checker.sv =====
// Checker for the matrix to quaternion converter: predicts and compares every rsp transfer.
module rotation_matrix_to_quaternion_checker import rmq_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // qx, qy, qz, qw
   input  logic [0:0]            rsp_tuser,   // degenerate
   output int                    fail_count,
   output int                    pending,
   output int                    result_count
);

   typedef struct packed {
      logic             degenerate;
      logic [3:0][17:0] comp;
   } quat_type;

   quat_type quat_q[$];

   function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic quat_type matrix_to_quat(logic [REQ_DATA_W-1:0] data);
      longint m [9];
      longint q [4];
      longint one;
      longint trace;
      longint unsigned s, a, inv, prod, mag, rt;
      int k, pick;
      quat_type res;
      one = longint'(1) << FRAC_BITS;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(data[i*IN_W +: IN_W]));
      trace = m[0] + m[4] + m[8];
      if (trace > 0) begin
         q[0] = m[7] - m[5];
         q[1] = m[2] - m[6];
         q[2] = m[3] - m[1];
         q[3] = one + trace;
      end else begin
         pick = 0;
         if (m[4] > m[0]) pick = 1;
         if (m[8] > m[pick*4]) pick = 2;
         case (pick)
            0: begin
               q[0] = one + m[0] - m[4] - m[8];
               q[1] = m[3] + m[1];
               q[2] = m[6] + m[2];
               q[3] = m[7] - m[5];
            end
            1: begin
               q[0] = m[1] + m[3];
               q[1] = one - m[0] + m[4] - m[8];
               q[2] = m[7] + m[5];
               q[3] = m[2] - m[6];
            end
            default: begin
               q[0] = m[2] + m[6];
               q[1] = m[5] + m[7];
               q[2] = one - m[0] - m[4] + m[8];
               q[3] = m[3] - m[1];
            end
         endcase
      end
      res = '0;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         a = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
         s = s + a * a;
      end
      if (s == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      k = 0;
      while (s < (64'd1 << 60)) begin
         s = s << 2;
         k++;
      end
      rt = root_floor(s);
      inv = (64'd1 << 62) / rt;
      for (int i = 0; i < 4; i++) begin
         a = ((q[i] < 0) ? longint'(-q[i]) : longint'(q[i])) << k;
         prod = a * inv;
         mag = (prod + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
         if (q[i] < 0)
            res.comp[i] = (mag > 131072) ? 18'h20000 : 18'(-longint'(mag));
         else
            res.comp[i] = (mag > 131071) ? 18'h1FFFF : 18'(mag);
      end
      return res;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      quat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (quat_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("ERROR: rsp transfer with nothing expected");
            end else begin
               want = quat_q.pop_front();
               for (int i = 0; i < 4; i++) begin
                  if (rsp_tdata[i*OUT_W +: OUT_W] !== want.comp[i]) begin
                     fail_count++;
                     if (fail_count <= 10)
                        $display("ERROR: component %0d expected %0d got %0d", i,
                                 $signed(want.comp[i]), $signed(rsp_tdata[i*OUT_W +: OUT_W]));
                  end
               end
               if (rsp_tuser[0] !== want.degenerate) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: degenerate expected %0b got %0b",
                              want.degenerate, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready) quat_q.push_back(matrix_to_quat(req_tdata));
      end
      pending = quat_q.size();
   end

endmodule

// ===== verif/rotation_matrix_to_quaternion_top_tb.sv =====
// Testbench top for the matrix to quaternion converter: stimulus, flow control and verdict.
module rotation_matrix_to_quaternion_top_tb;
   import rmq_pkg::*;

   localparam int  ONE       = 65536;
   localparam int  RAND_N    = 900;
   localparam int  LIMIT     = 400000;

   typedef logic [8:0][IN_W-1:0] matrix_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // r00, r01, r02, r10, r11, r12, r20, r21, r22
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // qx, qy, qz, qw
   logic [0:0]            rsp_tuser;        // degenerate
   logic                  quiet = 1'b0;
   int                    fail_count, pending, result_count;
   int                    cycles = 0;
   int                    sent = 0;

   rotation_matrix_to_quaternion_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   rotation_matrix_to_quaternion_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending), .result_count(result_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= quiet || ($urandom_range(99) >= 37);

   task automatic send_matrix(matrix_type m);
      while (!quiet && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, m};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_entries(int a0, int a1, int a2, int b0, int b1, int b2,
                               int c0, int c1, int c2);
      matrix_type m;
      m[0] = a0[17:0]; m[1] = a1[17:0]; m[2] = a2[17:0];
      m[3] = b0[17:0]; m[4] = b1[17:0]; m[5] = b2[17:0];
      m[6] = c0[17:0]; m[7] = c1[17:0]; m[8] = c2[17:0];
      send_matrix(m);
   endtask

   function automatic logic [17:0] near_unit();
      int v;
      v = $urandom_range(2 * ONE) - ONE;
      return v[17:0];
   endfunction

   initial begin
      matrix_type m;
      int mode;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_entries(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      send_entries(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
      send_entries(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_entries(131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071, 131071);
      send_entries(-131072, -131072, -131072, -131072, -131072, -131072, -131072, -131072,
                   -131072);
      send_entries(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
      send_entries(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
      send_entries(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE);
      send_entries(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE);
      send_entries(-100, 5, 7, 9, -100, 11, 13, 17, -200);
      send_entries(-200, 5, 7, 9, -100, 11, 13, 17, -100);
      send_entries(-300, 5, 7, 9, -200, 11, 13, 17, -200);
      send_entries(10, 1, 2, 3, -5, 4, 5, 6, -5);
      send_entries(10, 1, 2, 3, -5, 4, 5, 6, -4);
      send_entries(1, 131071, -131072, -131072, 0, 131071, 131071, -131072, 0);
      send_entries(-131072, 131071, -131072, 131071, -131072, 131071, -131072, 131071,
                   131071);
      send_entries(46341, -46341, 0, 46341, 46341, 0, 0, 0, ONE);
      send_entries(0, 1, -1, -1, 0, 1, 1, -1, 0);

      for (int n = 0; n < RAND_N; n++) begin
         if (n == 300) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
            quiet <= 1'b1;
         end
         if (n == 450) quiet <= 1'b0;
         mode = $urandom_range(9);
         for (int i = 0; i < 9; i++) begin
            if (mode < 3) m[i] = 18'($urandom);
            else if (mode < 9) m[i] = near_unit();
            else m[i] = 18'($urandom_range(40)) - 18'd20;
         end
         send_matrix(m);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d matrices (directed corner cases and random), checked %0d quaternions.",
               sent, result_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
